@@ rtl/core/idv_pkg.sv @@
// ----------------------------------------------------------------------------
// idv_pkg: identity number validator shared definitions
// Field widths, status codes, the MOD 11-2 weight and check tables.
// ----------------------------------------------------------------------------
package idv_pkg;

  localparam int LENGTH_CAP_DEF = 100;
  localparam int ID_LEN         = 18;
  localparam int BODY_LEN       = 17;
  localparam int YEAR_FLOOR     = 1000;
  localparam int YEAR_W         = 14;
  localparam int DATE_W         = 7;
  localparam int COUNT_W        = 7;

  localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2020;

  typedef logic [3:0] status_t;
  typedef logic [3:0] digit_t;

  localparam status_t ST_VALID     = 4'd0;
  localparam status_t ST_SHORT     = 4'd1;
  localparam status_t ST_LONG      = 4'd2;
  localparam status_t ST_BAD_CHAR  = 4'd3;
  localparam status_t ST_MONTH     = 4'd4;
  localparam status_t ST_EARLY     = 4'd5;
  localparam status_t ST_DAY_RANGE = 4'd6;
  localparam status_t ST_DAY_END   = 4'd7;
  localparam status_t ST_FUTURE    = 4'd8;
  localparam status_t ST_MISMATCH  = 4'd9;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOWX  = 8'h78;

  // Weight for body positions 0..16
  function automatic logic [3:0] weight_of(input logic [4:0] idx);
    logic [3:0] w;
    begin
      case (idx)
        5'd0:    w = 4'd7;
        5'd1:    w = 4'd9;
        5'd2:    w = 4'd10;
        5'd3:    w = 4'd5;
        5'd4:    w = 4'd8;
        5'd5:    w = 4'd4;
        5'd6:    w = 4'd2;
        5'd7:    w = 4'd1;
        5'd8:    w = 4'd6;
        5'd9:    w = 4'd3;
        5'd10:   w = 4'd7;
        5'd11:   w = 4'd9;
        5'd12:   w = 4'd10;
        5'd13:   w = 4'd5;
        5'd14:   w = 4'd8;
        5'd15:   w = 4'd4;
        5'd16:   w = 4'd2;
        default: w = 4'd0;
      endcase
      return w;
    end
  endfunction

  // Check character for a sum residue 0..10
  function automatic logic [7:0] check_char(input logic [3:0] r);
    logic [7:0] c;
    begin
      case (r)
        4'd0:    c = 8'h31;
        4'd1:    c = 8'h30;
        4'd2:    c = CH_UPX;
        4'd3:    c = 8'h39;
        4'd4:    c = 8'h38;
        4'd5:    c = 8'h37;
        4'd6:    c = 8'h36;
        4'd7:    c = 8'h35;
        4'd8:    c = 8'h34;
        4'd9:    c = 8'h33;
        4'd10:   c = 8'h32;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // Residue mod 11 for 7-bit values (below 128), by binary-weighted subtraction
  function automatic logic [3:0] mod11(input logic [6:0] s);
    logic [6:0] t;
    begin
      t = s;
      if (t >= 7'd88) t = t - 7'd88;
      if (t >= 7'd44) t = t - 7'd44;
      if (t >= 7'd22) t = t - 7'd22;
      if (t >= 7'd11) t = t - 7'd11;
      return t[3:0];
    end
  endfunction

endpackage

@@ rtl/core/id_number_validator_top.sv @@
// ----------------------------------------------------------------------------
// id_number_validator_top: 18-character identity number checker
// Streams characters, keeps the MOD 11-2 sum and date digits, and on the
// terminating NUL reports a status, the expected check character and a count.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_char_code        | input beat
//  out     | out_valid, out_ready, out_status,       | result beat
//          | out_expected_check, out_char_count      |
//  cfg     | cfg_we, cfg_wdata (current year)        | write only
//
// One character per cycle. A NUL beat loads the result register at its own
// edge, so the result is offered from the next cycle; the per-number state
// clears in the same edge, so the next number may start right away. in_ready
// drops only while a result waits and out_ready is low. Reset (rst_n,
// synchronous) clears all but the result payload, sets the current year to 2020.
// ----------------------------------------------------------------------------
module id_number_validator_top
  import idv_pkg::*;
#(
  parameter int LENGTH_CAP = LENGTH_CAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_status,
  output logic [7:0]         out_expected_check,
  output logic [COUNT_W-1:0] out_char_count,
  input  logic               cfg_we,
  input  logic [YEAR_W-1:0]  cfg_wdata
);

  localparam int PW = $clog2(LENGTH_CAP + 1);

  logic [YEAR_W-1:0] cur_year_r;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [3:0]        sum_r, sum_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  digit_t            yd_r [4];
  digit_t            yd_nxt [4];
  logic [DATE_W-1:0] month_r, month_nxt;
  logic [DATE_W-1:0] day_r, day_nxt;
  logic [7:0]        last_r, last_nxt;
  logic              bad_r, bad_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [7:0]         exp_r, exp_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic       beat, term, is_digit, in_body;
  digit_t     v;
  logic [3:0] w;
  logic [6:0] prod_sum;
  logic       cent, leap, div400;
  logic [1:0] cent_mod4;
  logic [4:0] mlen;
  logic [7:0] last_fold;

  assign in_ready = !out_valid_r || out_ready;
  assign beat     = in_valid && in_ready;
  assign term     = (in_char_code == 8'h00);
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign v        = is_digit ? 4'(in_char_code - CH_ZERO) : 4'd0;
  assign in_body  = (pos_r < PW'(BODY_LEN));
  assign w        = weight_of(pos_r[4:0]);
  assign prod_sum = 7'(sum_r) + 7'(v) * 7'(w);

  // Gregorian leap rule from the year value and its decimal year digits
  assign cent      = (yd_r[1] == 4'd0) && (yd_r[0] == 4'd0);
  assign cent_mod4 = 2'({yd_r[3][0], 1'b0} + yd_r[2][1:0]);
  assign div400    = cent && (cent_mod4 == 2'd0);
  assign leap      = ((year_r[1:0] == 2'd0) && !cent) || div400;

  always_comb begin
    if (month_r == 7'd2) begin
      mlen = leap ? 5'd29 : 5'd28;
    end else if (month_r == 7'd4 || month_r == 7'd6 || month_r == 7'd9 ||
                 month_r == 7'd11) begin
      mlen = 5'd30;
    end else begin
      mlen = 5'd31;
    end
  end

  assign last_fold = (last_r == CH_LOWX) ? CH_UPX : last_r;

  // Result of the number held in the state registers
  always_comb begin
    exp_nxt = (pos_r == PW'(ID_LEN)) ? check_char(sum_r) : 8'h00;
    if (pos_r < PW'(ID_LEN)) begin
      status_nxt = ST_SHORT;
    end else if (pos_r > PW'(ID_LEN)) begin
      status_nxt = ST_LONG;
    end else if (bad_r) begin
      status_nxt = ST_BAD_CHAR;
    end else if (month_r < 7'd1 || month_r > 7'd12) begin
      status_nxt = ST_MONTH;
    end else if (year_r <= YEAR_W'(YEAR_FLOOR)) begin
      status_nxt = ST_EARLY;
    end else if (day_r < 7'd1 || day_r > 7'd31) begin
      status_nxt = ST_DAY_RANGE;
    end else if (day_r > 7'(mlen)) begin
      status_nxt = ST_DAY_END;
    end else if (year_r > cur_year_r) begin
      status_nxt = ST_FUTURE;
    end else if (last_fold != exp_nxt) begin
      status_nxt = ST_MISMATCH;
    end else begin
      status_nxt = ST_VALID;
    end
    count_nxt = COUNT_W'(pos_r);
  end

  // Per-number state update
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    year_nxt  = year_r;
    yd_nxt    = yd_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    last_nxt  = last_r;
    bad_nxt   = bad_r;
    if (beat && term) begin
      pos_nxt   = '0;
      sum_nxt   = '0;
      year_nxt  = '0;
      yd_nxt    = '{default: '0};
      month_nxt = '0;
      day_nxt   = '0;
      last_nxt  = '0;
      bad_nxt   = 1'b0;
    end else if (beat) begin
      if (in_body) begin
        if (!is_digit) bad_nxt = 1'b1;
        sum_nxt = mod11(prod_sum);
        if (pos_r >= PW'(6) && pos_r <= PW'(9)) begin
          year_nxt  = YEAR_W'((year_r << 3) + (year_r << 1) + YEAR_W'(v));
          yd_nxt[3] = yd_r[2];
          yd_nxt[2] = yd_r[1];
          yd_nxt[1] = yd_r[0];
          yd_nxt[0] = v;
        end else if (pos_r >= PW'(10) && pos_r <= PW'(11)) begin
          month_nxt = DATE_W'((month_r << 3) + (month_r << 1) + DATE_W'(v));
        end else if (pos_r >= PW'(12) && pos_r <= PW'(13)) begin
          day_nxt = DATE_W'((day_r << 3) + (day_r << 1) + DATE_W'(v));
        end
      end else if (pos_r == PW'(BODY_LEN)) begin
        last_nxt = in_char_code;
        if (!is_digit && in_char_code != CH_UPX && in_char_code != CH_LOWX) begin
          bad_nxt = 1'b1;
        end
      end
      if (pos_r < PW'(LENGTH_CAP)) pos_nxt = pos_r + PW'(1);
    end
    out_valid_nxt = (beat && term) || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= YEAR_RESET;
      pos_r       <= '0;
      sum_r       <= '0;
      year_r      <= '0;
      yd_r        <= '{default: '0};
      month_r     <= '0;
      day_r       <= '0;
      last_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cur_year_r <= cfg_wdata;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      year_r      <= year_nxt;
      yd_r        <= yd_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      last_r      <= last_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on the terminating beat
  always_ff @(posedge clk) begin
    if (beat && term) begin
      status_r <= status_nxt;
      exp_r    <= exp_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_expected_check = exp_r;
  assign out_char_count     = count_r;

  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(LENGTH_CAP))
    else $error("character count beyond cap");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r < 4'd11)
    else $error("weighted sum residue out of range");

  a_term_load: assert property (@(posedge clk) disable iff (!rst_n)
    beat && term |=> out_valid_r && pos_r == '0 && !bad_r)
    else $error("terminator did not load result and clear state");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_VALID |-> exp_r != 8'h00 &&
      count_r == COUNT_W'(ID_LEN))
    else $error("valid status without full length");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
